// ===== rtl/mvp_pkg.sv =====
// Package with shared widths, register indexes and the X.25 checksum step of the frame packer.
package mvp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MsgIdW  = 24;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CFG_SYSTEM_ID    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COMPONENT_ID = 1'b1;

  localparam logic [ByteW-1:0] START_MARK     = 8'hFD;
  localparam logic [15:0]      CRC_INIT       = 16'hFFFF;
  localparam logic [ByteW-1:0] SYSTEM_ID_RST  = 8'd255;
  localparam logic [ByteW-1:0] COMP_ID_RST    = 8'd190;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [ByteW-1:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// ===== rtl/mvp_if.sv =====
// Stream interfaces for the payload input channel and the frame byte output channel.
interface mvp_in_if import mvp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  payload_byte;
  logic [MsgIdW-1:0] message_id;
  logic [ByteW-1:0]  payload_length;
  logic [ByteW-1:0]  sequence_number;
  logic [ByteW-1:0]  crc_seed_extra;

  modport source (
    output valid, payload_byte, message_id, payload_length, sequence_number, crc_seed_extra,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, message_id, payload_length, sequence_number, crc_seed_extra,
    output ready
  );
endinterface

interface mvp_out_if import mvp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] frame_byte;
  logic             end_of_frame;

  modport source (output valid, frame_byte, end_of_frame, input ready);
  modport sink (input valid, frame_byte, end_of_frame, output ready);
endinterface

// ===== rtl/mavlink_v2_frame_packer.sv =====
// Top level of the MAVLink v2 frame packer with its byte sequencer and checksum.
//
// The input channel carries payload bytes. The first transfer of a frame also
// carries the message id, payload length, sequence number and CRC extra byte;
// those fields are ignored on later transfers of the same frame. A length of
// zero makes a frame of header and checksum only from one transfer.
// The output channel carries the frame one byte per transfer, with
// end_of_frame set on the checksum high byte.
// An accepted item sits in an input register and its bytes are produced one
// per cycle into the output register while the receiver takes them, so the
// first byte of an item passes the input register and then the output register.
// The opening item of a frame gives the header and any first payload byte, a later
// payload byte just itself, the closing item also the checksum; the output register sets this pace.
// A new item is taken in the cycle its predecessor emits its final byte.
// When the receiver stalls, the output register holds its byte and the input
// channel stops after one held item. Reset empties both registers, closes any
// open frame and restores the system and component ids.
module mavlink_v2_frame_packer import mvp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  mvp_in_if.sink             in_ch,
  mvp_out_if.source          out_ch
);

  localparam logic [3:0] S_HDR0  = 4'd0;
  localparam logic [3:0] S_HDR1  = 4'd1;
  localparam logic [3:0] S_HDR2  = 4'd2;
  localparam logic [3:0] S_HDR3  = 4'd3;
  localparam logic [3:0] S_HDR4  = 4'd4;
  localparam logic [3:0] S_HDR5  = 4'd5;
  localparam logic [3:0] S_HDR6  = 4'd6;
  localparam logic [3:0] S_HDR7  = 4'd7;
  localparam logic [3:0] S_HDR8  = 4'd8;
  localparam logic [3:0] S_HDR9  = 4'd9;
  localparam logic [3:0] S_DATA  = 4'd10;
  localparam logic [3:0] S_CRCLO = 4'd11;
  localparam logic [3:0] S_CRCHI = 4'd12;

  logic [ByteW-1:0]  sys_id_q, comp_id_q;

  logic              item_vld_q, item_vld_d;
  logic [ByteW-1:0]  pay_q, len_q, seq_q, extra_in_q;
  logic [MsgIdW-1:0] id_q;

  logic [3:0]        step_q, step_d, step_nx;
  logic              inside_q, inside_nx;
  logic [ByteW-1:0]  rem_q, rem_nx;
  logic [ByteW-1:0]  extra_q, extra_nx;
  logic [15:0]       crc_q, crc_nx, crc_fin;

  logic              out_vld_q, out_vld_d;
  logic [ByteW-1:0]  out_byte_q, byte_nx;
  logic              out_eof_q, eof_nx;

  logic              adv, last, in_xfer;

  assign adv     = item_vld_q && (!out_vld_q || out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign crc_fin = crc_fold(crc_q, extra_q);

  always_comb begin
    step_nx   = step_q;
    inside_nx = inside_q;
    rem_nx    = rem_q;
    extra_nx  = extra_q;
    crc_nx    = crc_q;
    byte_nx   = '0;
    eof_nx    = 1'b0;
    last      = 1'b0;
    unique case (step_q)
      S_HDR0: begin
        byte_nx  = START_MARK;
        crc_nx   = CRC_INIT;
        extra_nx = extra_in_q;
        step_nx  = S_HDR1;
      end
      S_HDR1: begin
        byte_nx = len_q;
        step_nx = S_HDR2;
      end
      S_HDR2: begin
        byte_nx = '0;
        step_nx = S_HDR3;
      end
      S_HDR3: begin
        byte_nx = '0;
        step_nx = S_HDR4;
      end
      S_HDR4: begin
        byte_nx = seq_q;
        step_nx = S_HDR5;
      end
      S_HDR5: begin
        byte_nx = sys_id_q;
        step_nx = S_HDR6;
      end
      S_HDR6: begin
        byte_nx = comp_id_q;
        step_nx = S_HDR7;
      end
      S_HDR7: begin
        byte_nx = id_q[7:0];
        step_nx = S_HDR8;
      end
      S_HDR8: begin
        byte_nx = id_q[15:8];
        step_nx = S_HDR9;
      end
      S_HDR9: begin
        byte_nx = id_q[23:16];
        if (len_q == '0) begin
          step_nx = S_CRCLO;
        end else begin
          inside_nx = 1'b1;
          rem_nx    = len_q;
          step_nx   = S_DATA;
        end
      end
      S_DATA: begin
        byte_nx = pay_q;
        rem_nx  = rem_q - 8'd1;
        if (rem_nx == '0) begin
          step_nx = S_CRCLO;
        end else begin
          last = 1'b1;
        end
      end
      S_CRCLO: begin
        byte_nx = crc_fin[7:0];
        crc_nx  = crc_fin;
        step_nx = S_CRCHI;
      end
      S_CRCHI: begin
        byte_nx   = crc_q[15:8];
        eof_nx    = 1'b1;
        last      = 1'b1;
        crc_nx    = CRC_INIT;
        rem_nx    = '0;
        inside_nx = 1'b0;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    if ((step_q != S_HDR0) && (step_q <= S_DATA)) begin
      crc_nx = crc_fold(crc_q, byte_nx);
    end
  end

  assign in_ch.ready = !item_vld_q || (adv && last);

  always_comb begin
    item_vld_d = item_vld_q;
    step_d     = step_q;
    if (adv) begin
      step_d = step_nx;
      if (last) begin
        item_vld_d = 1'b0;
      end
    end
    if (in_xfer) begin
      item_vld_d = 1'b1;
      step_d     = (adv ? inside_nx : inside_q) ? S_DATA : S_HDR0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_id_q   <= SYSTEM_ID_RST;
      comp_id_q  <= COMP_ID_RST;
      item_vld_q <= 1'b0;
      step_q     <= S_HDR0;
      inside_q   <= 1'b0;
      rem_q      <= '0;
      extra_q    <= '0;
      crc_q      <= CRC_INIT;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SYSTEM_ID:    sys_id_q  <= cfg_wdata_i;
          CFG_COMPONENT_ID: comp_id_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      item_vld_q <= item_vld_d;
      step_q     <= step_d;
      out_vld_q  <= out_vld_d;
      if (adv) begin
        inside_q <= inside_nx;
        rem_q    <= rem_nx;
        extra_q  <= extra_nx;
        crc_q    <= crc_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pay_q      <= in_ch.payload_byte;
      id_q       <= in_ch.message_id;
      len_q      <= in_ch.payload_length;
      seq_q      <= in_ch.sequence_number;
      extra_in_q <= in_ch.crc_seed_extra;
    end
    if (adv) begin
      out_byte_q <= byte_nx;
      out_eof_q  <= eof_nx;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.frame_byte   = out_byte_q;
  assign out_ch.end_of_frame = out_eof_q;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q |-> (step_q <= S_CRCHI))
    else $error("Sequencer step outside the frame layout.");

  a_close_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (step_q == S_CRCHI)) |=> (!inside_q && (crc_q == CRC_INIT)))
    else $error("Frame still open after its checksum high byte.");

  a_rem_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inside_q && (rem_q == '0)) |-> (item_vld_q && ((step_q == S_CRCLO) || (step_q == S_CRCHI))))
    else $error("Open frame has no bytes left but is not closing.");

  a_idle_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!inside_q && !item_vld_q) |-> (crc_q == CRC_INIT))
    else $error("Checksum not at its initial value between frames.");
`endif

endmodule
